### hdl/pst_pkg.sv
`default_nettype none
package pst_pkg;

  localparam int MaxTokenLength = 255;
  localparam logic [7:0] LenCap =
    (MaxTokenLength < 255) ? 8'(MaxTokenLength) : 8'd255;

  localparam int NumKw = 11;
  localparam int KwMaxLen = 7;

  localparam int ItemDepthDefault = 4;
  localparam int ResultDepthDefault = 4;

  localparam logic [15:0] FirstLineReset = 16'd1;
  localparam logic [15:0] LineMax = 16'hFFFF;

  typedef enum logic [4:0] {
    TK_NUMBER, TK_IDENT, TK_PROGRAM, TK_VAR, TK_BEGIN, TK_TYPE, TK_BOOL,
    TK_END, TK_ARRAY, TK_OF, TK_DIV, TK_COMMA, TK_DOT, TK_COLON, TK_SEMI,
    TK_EQUAL, TK_PLUS, TK_MINUS, TK_STAR, TK_LBRACK, TK_RBRACK, TK_ASSIGN,
    TK_RANGE, TK_UNKNOWN, TK_EOF
  } tok_kind_t;

  typedef enum logic [2:0] {
    CC_SPACE, CC_NEWLINE, CC_DIGIT, CC_LETTER, CC_COLON, CC_DOT, CC_EQUAL, CC_MARK
  } char_class_t;

  typedef enum logic [2:0] {
    SM_IDLE, SM_NUM, SM_IDENT, SM_COLON, SM_DOT
  } scan_mode_t;

  typedef struct packed {
    logic        eoi;
    char_class_t cls;
    logic [7:0]  code;
    tok_kind_t   mark;
  } item_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [15:0] line;
    logic [7:0]  len;
    logic        last;
  } tok_rec_t;

  // keyword text, left aligned, zero padded
  localparam logic [55:0] KwText [NumKw] = '{
    "program", "integer", "boolean", {"array", 16'h0}, {"begin", 16'h0},
    {"false", 16'h0}, {"true", 24'h0}, {"var", 32'h0}, {"end", 32'h0},
    {"div", 32'h0}, {"of", 40'h0}
  };

  localparam logic [7:0] KwLen [NumKw] = '{
    8'd7, 8'd7, 8'd7, 8'd5, 8'd5, 8'd5, 8'd4, 8'd3, 8'd3, 8'd3, 8'd2
  };

  localparam tok_kind_t KwKind [NumKw] = '{
    TK_PROGRAM, TK_TYPE, TK_TYPE, TK_ARRAY, TK_BEGIN, TK_BOOL, TK_BOOL,
    TK_VAR, TK_END, TK_DIV, TK_OF
  };

endpackage
`default_nettype wire

### hdl/pst_front.sv
`default_nettype none
module pst_front import pst_pkg::*; #(
  parameter int ITEM_DEPTH = ItemDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic       kind,
  input  wire logic [7:0] char_code,
  output logic            out_valid,
  output item_t           out_item,
  input  wire logic       out_ready
);

  localparam int PW = (ITEM_DEPTH > 1) ? $clog2(ITEM_DEPTH) : 1;
  localparam int CW = $clog2(ITEM_DEPTH + 1);

  item_t          mem [ITEM_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push_take;
  logic           pop_take;
  item_t          cls_item;

  always_comb begin
    cls_item.eoi  = kind;
    cls_item.code = char_code;
    cls_item.mark = TK_UNKNOWN;
    case (char_code) inside
      8'h20, 8'h09, 8'h0D:          cls_item.cls = CC_SPACE;
      8'h0A:                        cls_item.cls = CC_NEWLINE;
      [8'h30:8'h39]:                cls_item.cls = CC_DIGIT;
      [8'h41:8'h5A], [8'h61:8'h7A]: cls_item.cls = CC_LETTER;
      8'h3A:                        cls_item.cls = CC_COLON;
      8'h2E:                        cls_item.cls = CC_DOT;
      8'h3D:                        cls_item.cls = CC_EQUAL;
      default:                      cls_item.cls = CC_MARK;
    endcase
    case (char_code)
      8'h2C:   cls_item.mark = TK_COMMA;
      8'h3B:   cls_item.mark = TK_SEMI;
      8'h3D:   cls_item.mark = TK_EQUAL;
      8'h2B:   cls_item.mark = TK_PLUS;
      8'h2D:   cls_item.mark = TK_MINUS;
      8'h2A:   cls_item.mark = TK_STAR;
      8'h5B:   cls_item.mark = TK_LBRACK;
      8'h5D:   cls_item.mark = TK_RBRACK;
      8'h2F:   cls_item.mark = TK_DIV;
      default: cls_item.mark = TK_UNKNOWN;
    endcase
  end

  assign full      = (count == CW'(ITEM_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign push_take = push && !full;
  assign pop_take  = out_ready && out_valid;

  always_ff @(posedge clk) begin
    if (push_take) begin
      mem[wr_ptr] <= cls_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_take) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CW'(push_take) - CW'(pop_take);
    end
  end

endmodule
`default_nettype wire

### hdl/pst_scan.sv
`default_nettype none
module pst_scan import pst_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire item_t       in_item,
  output logic             in_ready,
  input  wire logic        room2,
  output logic [1:0]       wr_n,
  output tok_rec_t         wr0,
  output tok_rec_t         wr1,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_data
);

  scan_mode_t       mode;
  scan_mode_t       mode_next;
  logic [7:0]       run_len;
  logic [7:0]       run_len_next;
  logic [NumKw-1:0] cand;
  logic [NumKw-1:0] cand_next;
  logic [15:0]      line;
  logic [15:0]      line_next;
  logic [15:0]      first_line;

  logic             take;
  logic             flush_valid;
  tok_rec_t         flush_rec;
  logic             st_valid;
  tok_rec_t         st_rec;
  tok_rec_t         rec0;
  tok_rec_t         rec1;
  logic [1:0]       nres;
  tok_kind_t        word_kind;
  logic [7:0]       run_len_inc;

  function automatic logic [NumKw-1:0] grow(input logic [NumKw-1:0] c_in,
                                            input logic [7:0] p,
                                            input logic [7:0] ch);
    logic [NumKw-1:0] r;
    int               idx;
    for (int i = 0; i < NumKw; i++) begin
      idx  = 55 - 8 * int'(p[2:0]);
      r[i] = c_in[i] && (p < KwLen[i]) && (KwText[i][idx -: 8] == ch);
    end
    return r;
  endfunction

  assign in_ready    = room2;
  assign take        = in_valid && room2;
  assign run_len_inc = (run_len < LenCap) ? run_len + 8'd1 : run_len;

  always_comb begin
    word_kind = TK_IDENT;
    for (int i = NumKw - 1; i >= 0; i--) begin
      if (cand[i] && (KwLen[i] == run_len)) begin
        word_kind = KwKind[i];
      end
    end
  end

  always_comb begin
    flush_valid    = 1'b1;
    flush_rec      = '0;
    flush_rec.line = line;
    flush_rec.len  = run_len;
    case (mode)
      SM_NUM:   flush_rec.kind = TK_NUMBER;
      SM_IDENT: flush_rec.kind = word_kind;
      SM_COLON: begin
        flush_rec.kind = TK_COLON;
        flush_rec.len  = 8'd1;
      end
      SM_DOT: begin
        flush_rec.kind = TK_DOT;
        flush_rec.len  = 8'd1;
      end
      default: flush_valid = 1'b0;
    endcase
  end

  always_comb begin
    mode_next    = mode;
    run_len_next = run_len;
    cand_next    = cand;
    line_next    = line;
    rec0         = '0;
    rec1         = '0;
    rec0.line    = line;
    rec1.line    = line;
    nres         = 2'd0;
    st_valid     = 1'b0;
    st_rec       = '0;
    st_rec.line  = line;
    st_rec.len   = 8'd1;

    if (in_item.eoi) begin
      rec1.kind = TK_EOF;
      if (flush_valid) begin
        rec0 = flush_rec;
        nres = 2'd2;
      end else begin
        rec0.kind = TK_EOF;
        nres      = 2'd1;
      end
      mode_next    = SM_IDLE;
      run_len_next = '0;
      cand_next    = '1;
      line_next    = first_line;
    end else if (mode == SM_NUM && in_item.cls == CC_DIGIT) begin
      run_len_next = run_len_inc;
    end else if (mode == SM_IDENT &&
                 (in_item.cls == CC_DIGIT || in_item.cls == CC_LETTER)) begin
      cand_next    = grow(cand, run_len, in_item.code);
      run_len_next = run_len_inc;
    end else if (mode == SM_COLON && in_item.cls == CC_EQUAL) begin
      rec0.kind    = TK_ASSIGN;
      rec0.len     = 8'd2;
      nres         = 2'd1;
      mode_next    = SM_IDLE;
      run_len_next = '0;
    end else if (mode == SM_DOT && in_item.cls == CC_DOT) begin
      rec0.kind    = TK_RANGE;
      rec0.len     = 8'd2;
      nres         = 2'd1;
      mode_next    = SM_IDLE;
      run_len_next = '0;
    end else begin
      mode_next    = SM_IDLE;
      run_len_next = '0;
      cand_next    = '1;
      case (in_item.cls)
        CC_SPACE: ;
        CC_NEWLINE: begin
          if (line != LineMax) begin
            line_next = line + 16'd1;
          end
        end
        CC_DIGIT: begin
          mode_next    = SM_NUM;
          run_len_next = 8'd1;
        end
        CC_LETTER: begin
          mode_next    = SM_IDENT;
          run_len_next = 8'd1;
          cand_next    = grow('1, 8'd0, in_item.code);
        end
        CC_COLON: begin
          mode_next    = SM_COLON;
          run_len_next = 8'd1;
        end
        CC_DOT: begin
          mode_next    = SM_DOT;
          run_len_next = 8'd1;
        end
        default: begin
          st_valid    = 1'b1;
          st_rec.kind = in_item.mark;
        end
      endcase
      if (flush_valid) begin
        rec0 = flush_rec;
        rec1 = st_rec;
        nres = st_valid ? 2'd2 : 2'd1;
      end else if (st_valid) begin
        rec0 = st_rec;
        nres = 2'd1;
      end
    end

    rec0.last = (nres == 2'd1);
    rec1.last = 1'b1;
  end

  assign wr0  = rec0;
  assign wr1  = rec1;
  assign wr_n = take ? nres : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= SM_IDLE;
      run_len    <= '0;
      cand       <= '1;
      first_line <= FirstLineReset;
      line       <= FirstLineReset;
    end else begin
      if (take) begin
        mode    <= mode_next;
        run_len <= run_len_next;
        cand    <= cand_next;
        line    <= line_next;
      end
      if (cfg_we) begin
        first_line <= cfg_data;
        line       <= cfg_data;
      end
    end
  end

  a_idle_len : assert property (@(posedge clk) disable iff (rst)
    mode == SM_IDLE |-> run_len == 8'd0)
    else $error("run length left over in idle");

  a_ident_len : assert property (@(posedge clk) disable iff (rst)
    mode == SM_IDENT |-> run_len != 8'd0)
    else $error("empty word pending");

  a_eof_line : assert property (@(posedge clk) disable iff (rst)
    take && in_item.eoi |=> line == first_line)
    else $error("line count not reloaded after end of input");

endmodule
`default_nettype wire

### hdl/pst_res_q.sv
`default_nettype none
module pst_res_q import pst_pkg::*; #(
  parameter int RESULT_DEPTH = ResultDepthDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] wr_n,
  input  wire tok_rec_t   wr0,
  input  wire tok_rec_t   wr1,
  output logic            room2,
  output logic            empty,
  input  wire logic       pop,
  output tok_rec_t        head
);

  localparam int PW = (RESULT_DEPTH > 1) ? $clog2(RESULT_DEPTH) : 1;
  localparam int CW = $clog2(RESULT_DEPTH + 1);

  tok_rec_t       mem [RESULT_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           pop_take;

  assign empty    = (count == '0);
  assign room2    = (count <= CW'(RESULT_DEPTH - 2));
  assign pop_take = pop && !empty;
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem[wr_ptr + 1'b1] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(wr_n);
      if (pop_take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CW'(wr_n) - CW'(pop_take);
    end
  end

  a_no_overfill : assert property (@(posedge clk) disable iff (rst)
    wr_n != 2'd0 |-> room2)
    else $error("result beat written without room");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(RESULT_DEPTH))
    else $error("result queue count out of range");

endmodule
`default_nettype wire

### hdl/pascal_subset_tokenizer_unit.sv
`default_nettype none
// channel   direction  handshake                 payload
// input     in         push / full               kind, char_code
// result    out        empty / pop               token_kind, line_number,
//                                                token_length, last
// config    in         cfg_valid / cfg_ready     cfg_data (first line number)
//
// One character beat per cycle sustained while full is low; the scanner takes
// one item a cycle from the item queue while room2 is high, and each result is
// registered into the result queue, whose head drives the result ports.
// An item gives up to two result beats; the port drains one per cycle on pop.
// Synchronous rst empties both queues, idles the scanner, line number to 1.
// full rises when ITEM_DEPTH beats wait; the scanner waits while the result
// queue has fewer than two free slots. cfg_ready is always high.
module pascal_subset_tokenizer_unit import pst_pkg::*; #(
  parameter int ITEM_DEPTH   = ItemDepthDefault,
  parameter int RESULT_DEPTH = ResultDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind,
  input  wire logic [7:0]  char_code,
  output logic             empty,
  input  wire logic        pop,
  output logic [4:0]       token_kind,
  output logic [15:0]      line_number,
  output logic [7:0]       token_length,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic       item_valid;
  item_t      item;
  logic       item_ready;
  logic       room2;
  logic [1:0] wr_n;
  tok_rec_t   wr0;
  tok_rec_t   wr1;
  tok_rec_t   head;

  assign cfg_ready = 1'b1;

  pst_front #(
    .ITEM_DEPTH(ITEM_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .char_code (char_code),
    .out_valid (item_valid),
    .out_item  (item),
    .out_ready (item_ready)
  );

  pst_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_valid),
    .in_item  (item),
    .in_ready (item_ready),
    .room2    (room2),
    .wr_n     (wr_n),
    .wr0      (wr0),
    .wr1      (wr1),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

  pst_res_q #(
    .RESULT_DEPTH(RESULT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr_n  (wr_n),
    .wr0   (wr0),
    .wr1   (wr1),
    .room2 (room2),
    .empty (empty),
    .pop   (pop),
    .head  (head)
  );

  assign token_kind   = head.kind;
  assign line_number  = head.line;
  assign token_length = head.len;
  assign last         = head.last;

endmodule
`default_nettype wire

### bench/tb_top.sv
module tb_top;
  import pst_pkg::*;

  localparam int DrainCycles = 8;
  localparam int PhaseBeats = 215;

  typedef struct packed {
    logic       k;
    logic [7:0] c;
    logic       typed;
    tok_kind_t  tk;
  } script_row_t;

  // typed rows each give one token, length 1, on the first line after reset
  localparam script_row_t Script [25] = '{
    '{1'b0, 8'h00, 1'b1, TK_UNKNOWN}, '{1'b0, 8'hFF, 1'b1, TK_UNKNOWN},
    '{1'b0, 8'h7F, 1'b1, TK_UNKNOWN}, '{1'b0, "!", 1'b1, TK_UNKNOWN},
    '{1'b0, ",", 1'b1, TK_COMMA}, '{1'b0, ";", 1'b1, TK_SEMI},
    '{1'b0, "=", 1'b1, TK_EQUAL}, '{1'b0, "+", 1'b1, TK_PLUS},
    '{1'b0, "-", 1'b1, TK_MINUS}, '{1'b0, "*", 1'b1, TK_STAR},
    '{1'b0, "[", 1'b1, TK_LBRACK}, '{1'b0, "]", 1'b1, TK_RBRACK},
    '{1'b0, "/", 1'b1, TK_DIV},
    '{1'b0, ":", 1'b0, TK_EOF}, '{1'b0, "=", 1'b0, TK_EOF},
    '{1'b0, ":", 1'b0, TK_EOF}, '{1'b0, ";", 1'b0, TK_EOF},
    '{1'b0, ".", 1'b0, TK_EOF}, '{1'b0, ".", 1'b0, TK_EOF},
    '{1'b0, ".", 1'b0, TK_EOF}, '{1'b0, 8'h0A, 1'b0, TK_EOF},
    '{1'b0, "z", 1'b0, TK_EOF}, '{1'b0, "0", 1'b0, TK_EOF},
    '{1'b0, " ", 1'b0, TK_EOF}, '{1'b1, 8'h00, 1'b0, TK_EOF}
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        kind = 1'b0;
  logic [7:0]  char_code = 8'h00;
  logic        pop = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data = 16'h0000;
  logic        full, empty, cfg_ready, last;
  logic [4:0]  token_kind;
  logic [15:0] line_number;
  logic [7:0]  token_length;

  pascal_subset_tokenizer_unit uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .kind(kind), .char_code(char_code),
    .empty(empty), .pop(pop), .token_kind(token_kind), .line_number(line_number),
    .token_length(token_length), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  string     kw_word [NumKw] = '{
    "program", "integer", "boolean", "array", "begin", "false",
    "true", "var", "end", "div", "of"
  };
  tok_kind_t kw_tok [NumKw] = '{
    TK_PROGRAM, TK_TYPE, TK_TYPE, TK_ARRAY, TK_BEGIN, TK_BOOL, TK_BOOL,
    TK_VAR, TK_END, TK_DIV, TK_OF
  };

  scan_mode_t  scan_st;
  logic [7:0]  run_len;
  logic [10:0] kw_live;
  logic [15:0] line_now, line_first;

  tok_rec_t tokens_due [$];
  tok_rec_t beat_toks [$];

  bit tx_gappy = 1'b1;
  bit rx_gappy = 1'b1;
  int errors = 0;
  int beats_sent = 0;
  int toks_checked = 0;
  int eofs_seen = 0;
  int cfg_writes = 0;
  int long_runs = 0;
  int long_kind = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #4_800_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic void note_tok(tok_kind_t tk, logic [7:0] n);
    beat_toks.push_back('{tk, line_now, n, 1'b0});
  endfunction

  function automatic void grow_word(logic [7:0] c);
    for (int i = 0; i < NumKw; i++)
      if (run_len >= KwMaxLen || run_len >= kw_word[i].len() || kw_word[i][run_len] != c)
        kw_live[i] = 1'b0;
    if (run_len < LenCap) run_len++;
  endfunction

  function automatic void flush_pending();
    tok_kind_t wk;
    case (scan_st)
      SM_NUM: note_tok(TK_NUMBER, run_len);
      SM_IDENT: begin
        wk = TK_IDENT;
        for (int i = NumKw - 1; i >= 0; i--)
          if (kw_live[i] && kw_word[i].len() == run_len) wk = kw_tok[i];
        note_tok(wk, run_len);
      end
      SM_COLON: note_tok(TK_COLON, 8'd1);
      SM_DOT: note_tok(TK_DOT, 8'd1);
      default: ;
    endcase
    scan_st = SM_IDLE;
    run_len = 8'd0;
    kw_live = '1;
  endfunction

  function automatic void tokenize(logic k, logic [7:0] c);
    tok_kind_t mk;
    beat_toks.delete();
    if (k) begin
      flush_pending();
      note_tok(TK_EOF, 8'd0);
      line_now = line_first;
    end else if (scan_st == SM_NUM && is_digit(c)) begin
      if (run_len < LenCap) run_len++;
    end else if (scan_st == SM_IDENT && (is_digit(c) || is_letter(c))) begin
      grow_word(c);
    end else if (scan_st == SM_COLON && c == "=") begin
      note_tok(TK_ASSIGN, 8'd2);
      scan_st = SM_IDLE;
      run_len = 8'd0;
    end else if (scan_st == SM_DOT && c == ".") begin
      note_tok(TK_RANGE, 8'd2);
      scan_st = SM_IDLE;
      run_len = 8'd0;
    end else begin
      flush_pending();
      if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) begin
        if (c == 8'h0A && line_now != LineMax) line_now++;
      end else if (is_digit(c)) begin
        scan_st = SM_NUM;
        run_len = 8'd1;
      end else if (is_letter(c)) begin
        scan_st = SM_IDENT;
        run_len = 8'd0;
        kw_live = '1;
        grow_word(c);
      end else if (c == ":") begin
        scan_st = SM_COLON;
        run_len = 8'd1;
      end else if (c == ".") begin
        scan_st = SM_DOT;
        run_len = 8'd1;
      end else begin
        case (c)
          ",": mk = TK_COMMA;
          ";": mk = TK_SEMI;
          "=": mk = TK_EQUAL;
          "+": mk = TK_PLUS;
          "-": mk = TK_MINUS;
          "*": mk = TK_STAR;
          "[": mk = TK_LBRACK;
          "]": mk = TK_RBRACK;
          "/": mk = TK_DIV;
          default: mk = TK_UNKNOWN;
        endcase
        note_tok(mk, 8'd1);
      end
    end
    if (beat_toks.size() > 0) beat_toks[beat_toks.size() - 1].last = 1'b1;
    foreach (beat_toks[i]) tokens_due.push_back(beat_toks[i]);
  endfunction

  task automatic send_beat(input logic k, input logic [7:0] c, input logic typed,
                           input tok_kind_t tk);
    int base;
    while (tx_gappy && $urandom_range(99) < 25) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    kind <= k;
    char_code <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    base = tokens_due.size();
    tokenize(k, c);
    if (typed) begin
      while (tokens_due.size() > base) void'(tokens_due.pop_back());
      tokens_due.push_back('{tk, FirstLineReset, 8'd1, 1'b1});
    end
    beats_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    send_beat(1'b0, c, 1'b0, TK_EOF);
  endtask

  task automatic send_eof();
    send_beat(1'b1, 8'($urandom_range(255)), 1'b0, TK_EOF);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    return ($urandom_range(3) == 0) ? 8'("0" + $urandom_range(9)) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(5))
      0: return 8'h09;
      1: return 8'h0D;
      2, 3: return 8'h0A;
      default: return " ";
    endcase
  endfunction

  // drain: nothing owed and the scanner has had time to settle
  task automatic quiesce();
    push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_first_line(input logic [15:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    line_first = v;
    line_now = v;
    cfg_writes++;
  endtask

  task automatic send_lexeme();
    int pick, n, i, v;
    string punct;
    punct = ":=.,;+-*[]/";
    pick = $urandom_range(99);
    if (pick < 20) begin
      i = $urandom_range(NumKw - 1);
      v = $urandom_range(9);
      n = kw_word[i].len();
      if (v == 6) n = $urandom_range(n - 1, 1);
      for (int j = 0; j < n; j++)
        send_char((v == 8 && j == 0) ? kw_word[i][j] - 8'd32 : kw_word[i][j]);
      if (v == 7) send_char(rand_letter());
      if (v == 9) send_char(8'("0" + $urandom_range(9)));
    end else if (pick < 35) begin
      send_char(rand_letter());
      n = $urandom_range(9);
      repeat (n) send_char(rand_alnum());
    end else if (pick < 48) begin
      n = $urandom_range(6, 1);
      repeat (n) send_char(8'("0" + $urandom_range(9)));
    end else if (pick < 68) begin
      v = $urandom_range(13);
      if (v == 11) begin
        send_char(":");
        send_char("=");
      end else if (v == 12) begin
        send_char(".");
        send_char(".");
      end else if (v == 13) begin
        send_char(8'($urandom_range(126, 33)));
      end else begin
        send_char(punct[v]);
      end
    end else if (pick < 86) begin
      send_char(rand_space());
    end else if (pick < 94) begin
      send_char(8'($urandom_range(255)));
    end else if (pick < 97) begin
      send_eof();
    end else if (long_kind != 0) begin
      // run past the length cap
      n = $urandom_range(262, 256);
      if (long_kind == 1) begin
        send_char(rand_letter());
        repeat (n - 1) send_char(rand_alnum());
      end else begin
        repeat (n) send_char(8'("0" + $urandom_range(9)));
      end
      long_kind = 0;
      long_runs++;
    end else begin
      send_char(" ");
    end
    if (pick < 48 && $urandom_range(99) < 70) send_char(rand_space());
  endtask

  always @(posedge clk) begin
    tok_rec_t want, seen;
    if (!rst && pop && !empty) begin
      seen = '{tok_kind_t'(token_kind), line_number, token_length, last};
      if (tokens_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected token beat: kind %0d line %0d len %0d last %0b",
                   token_kind, line_number, token_length, last);
      end else begin
        want = tokens_due.pop_front();
        toks_checked++;
        if (want.kind == TK_EOF) eofs_seen++;
        if (seen !== want) begin
          errors++;
          if (errors <= 10)
            $display("token mismatch: expected kind %0d line %0d len %0d last %0b, got kind %0d line %0d len %0d last %0b",
                     want.kind, want.line, want.len, want.last,
                     token_kind, line_number, token_length, last);
        end
      end
    end
    pop <= !rx_gappy || ($urandom_range(99) >= 25);
  end

  initial begin
    logic [15:0] first_vals [5];
    int target;
    first_vals = '{16'd0, 16'hFFFF, 16'hFFFD, 16'($urandom_range(65535)), 16'd1};
    scan_st = SM_IDLE;
    run_len = 8'd0;
    kw_live = '1;
    line_first = FirstLineReset;
    line_now = FirstLineReset;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (Script[r]) send_beat(Script[r].k, Script[r].c, Script[r].typed, Script[r].tk);

    for (int p = 0; p < 5; p++) begin
      set_first_line(first_vals[p]);
      tx_gappy = (p != 2);
      rx_gappy = (p != 2);
      if (p == 1) long_kind = 1;
      if (p == 3) long_kind = 2;
      target = beats_sent + PhaseBeats;
      while (beats_sent < target) begin
        send_lexeme();
        if (p == 0 && beats_sent >= target - PhaseBeats / 2 && beats_sent < target - 90)
          quiesce();
      end
      send_eof();
    end

    push <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d beats over %0d first-line settings; %0d tokens checked, %0d of them EOF",
             beats_sent, cfg_writes, toks_checked, eofs_seen);
    $display("%0d over-length runs, %0d mismatches", long_runs, errors);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
